FILE: sv/fcpa_pkg.sv
// Shared types and constants for the fixed chunk pool allocator.
package fcpa_pkg;

  localparam int unsigned MaxChunks = 1024;
  localparam int unsigned LinkAw    = $clog2(MaxChunks);
  localparam int unsigned IdxW      = 11;
  localparam int unsigned GrantW    = 10;
  localparam int unsigned LinkW     = 11;

  localparam logic [IdxW-1:0] PoolReset = IdxW'(1024);

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic            command;
    logic [IdxW-1:0] chunk_index;
  } fcpa_in_t;

  typedef struct packed {
    logic [GrantW-1:0] granted_index;
    logic              fallback;
    logic              pool_empty;
  } fcpa_out_t;

  typedef enum logic {
    StIdle,
    StWork
  } fcpa_state_e;

endpackage

FILE: sv/fixed_chunk_pool_allocator_core.sv
// Top level of the fixed chunk pool allocator: control, state registers, link RAM.
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_data_i): one command item, either
//     allocate a chunk or free the chunk given by chunk_index.
//   out channel (out_valid_o / out_ready_i / out_data_o): exactly one result
//     item per command: granted index, fallback flag, pool empty flag.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the pool size
//     and restarts the free list (head, init pointer, free count). Write only
//     while no command is in flight; ready when idle, and wins over the in channel.
// Timing: a command is accepted in the idle state, which issues the link read;
//   the link RAM returns it from its registered read port, and in the work
//   state the result is loaded into the output register once that is free.
//   A new command is taken only after the work state ends, since the next
//   head comes from the popped chunk's link read from the link RAM.
// Stall: a pending result sits in the output register while the next command
//   is accepted; the work cycle holds until the output register is free.
// Reset: pool size 1024, free count 1024, head and init pointer 0. The link
//   RAM is not cleared; entries are threaded lazily before they are popped.
module fixed_chunk_pool_allocator_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fcpa_pkg::fcpa_in_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output fcpa_pkg::fcpa_out_t    out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [fcpa_pkg::IdxW-1:0] cfg_data_i
);

  import fcpa_pkg::*;

  fcpa_state_e state_q, state_d;

  logic [IdxW-1:0]  pool_q, pool_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  init_q, init_d;
  logic [IdxW-1:0]  count_q, count_d;

  logic             pop_q, pop_d;
  logic             byp_q, byp_d;
  logic             oob_q, oob_d;
  logic [LinkW-1:0] byp_data_q, byp_data_d;
  fcpa_out_t        res_q, res_d;

  logic             out_valid_q, out_valid_d;
  fcpa_out_t        out_data_q, out_data_d;

  logic              ram_we, ram_re;
  logic [LinkAw-1:0] ram_waddr;
  logic [LinkW-1:0]  ram_wdata;
  logic [LinkW-1:0]  ram_rdata;
  logic [IdxW-1:0]   waddr_full;

  logic in_fire, cfg_fire, lazy_en, slot_free;

  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign lazy_en     = (init_q < pool_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    pool_d      = pool_q;
    head_d      = head_q;
    init_d      = init_q;
    count_d     = count_q;
    pop_d       = pop_q;
    byp_d       = byp_q;
    oob_d       = oob_q;
    byp_data_d  = byp_data_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    waddr_full  = init_q;
    ram_wdata   = LinkW'(init_q + IdxW'(1));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (cfg_fire) begin
          pool_d  = cfg_data_i;
          head_d  = '0;
          init_d  = '0;
          count_d = cfg_data_i;
        end else if (in_fire) begin
          res_d = '0;
          pop_d = 1'b0;
          if (in_data_i.command == CmdAlloc) begin
            // lazily thread the next untouched chunk
            if (lazy_en) begin
              waddr_full = init_q;
              ram_wdata  = LinkW'(init_q + IdxW'(1));
              ram_we     = (32'(init_q) < MaxChunks);
              init_d     = IdxW'(init_q + IdxW'(1));
            end
            if (count_q == '0) begin
              res_d.fallback = 1'b1;
            end else begin
              count_d             = IdxW'(count_q - IdxW'(1));
              res_d.granted_index = head_q[GrantW-1:0];
              pop_d               = 1'b1;
              ram_re              = 1'b1;
            end
            // same-entry write and read in the same cycle: forward the new link
            byp_d      = lazy_en && (head_q == init_q);
            byp_data_d = LinkW'(init_q + IdxW'(1));
            oob_d      = !(32'(head_q) < MaxChunks);
          end else begin
            if (in_data_i.chunk_index >= pool_q) begin
              res_d.fallback = 1'b1;
            end else begin
              count_d    = IdxW'(count_q + IdxW'(1));
              waddr_full = in_data_i.chunk_index;
              ram_wdata  = LinkW'(head_q);
              ram_we     = (32'(in_data_i.chunk_index) < MaxChunks);
              head_d     = in_data_i.chunk_index;
            end
          end
          res_d.pool_empty = (count_d == '0);
          state_d = StWork;
        end
      end
      StWork: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          if (pop_q) begin
            if (byp_q) begin
              head_d = IdxW'(byp_data_q);
            end else if (oob_q) begin
              head_d = '0;
            end else begin
              head_d = IdxW'(ram_rdata);
            end
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign ram_waddr = waddr_full[LinkAw-1:0];

  fcpa_ram #(
    .Width (LinkW),
    .Depth (MaxChunks)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q[LinkAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pool_q      <= PoolReset;
      head_q      <= '0;
      init_q      <= '0;
      count_q     <= PoolReset;
      pop_q       <= 1'b0;
      byp_q       <= 1'b0;
      oob_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      head_q      <= head_d;
      init_q      <= init_d;
      count_q     <= count_d;
      pop_q       <= pop_d;
      byp_q       <= byp_d;
      oob_q       <= oob_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= byp_data_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

FILE: sv/fcpa_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module fcpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
